FILE: hdl/traffic_rate_meter_with_history_defines.svh
// assertion macros for the traffic rate meter
// used by the top level, expects clk_i and rst_ni in scope
`ifndef TRAFFIC_RATE_METER_WITH_HISTORY_DEFINES_SVH
`define TRAFFIC_RATE_METER_WITH_HISTORY_DEFINES_SVH

// checked only while out of reset
`define TRMH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define TRMH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hdl/trmh_pkg.sv
// types and constants of the traffic rate meter
// no dependencies
`default_nettype none

package trmh_pkg;

  localparam int unsigned CNT_W    = 64;  // byte counter
  localparam int unsigned TOT_W    = 63;  // report totals, only the low bits are visible
  localparam int unsigned SPD_W    = 32;  // speed
  localparam int unsigned PACK_W   = 16;  // packed ring entry
  localparam int unsigned SUM_W    = 35;  // exact sum of five speeds
  localparam int unsigned DVS_W    = 6;   // divisor up to 63
  localparam int unsigned DIV_STEP = 8;   // quotient bits per divider cycle
  localparam int unsigned TERM_W   = 3;   // average term count 1..5

  localparam logic [SPD_W-1:0]  PACK_LIMIT = 32'd131072;
  localparam logic [TERM_W-1:0] TERM_MAX   = 3'd5;

  typedef enum logic [0:0] {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic        command;
    logic [31:0] byte_amount;
    logic [5:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [31:0] current_speed;
    logic [15:0] speed_code;
    logic [31:0] average_speed;
    logic [62:0] byte_count;
    logic [62:0] report_total_a;
    logic [62:0] report_total_b;
    logic [62:0] db_total;
  } result_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] amount;
    logic [5:0]  slot;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } front_req_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

FILE: hdl/traffic_rate_meter_with_history.sv
// Traffic rate meter with speed history, top level.
// Input channel: push / full, one beat is an add command (byte_amount goes
// onto the 64-bit counter) or a refresh tick (speed, ring slot, totals, average).
// Result channel: empty / pop, every input beat gives exactly one result beat.
// Configuration: cfg_we_i writes ring_length (7 bits, resets to 64).
// An add goes from acceptance through ST_IDLE and ST_DONE to its result; a
// refresh makes k = min(ring_length, 4) history reads. A refresh makes two
// passes through the shared divider (8 quotient bits per cycle) and uses one
// ring memory read port, each entry read in ST_RADDR and then ST_RDATA.
// Items are worked on one at a time; a two-entry queue ahead of the
// executer takes new beats while it works.
// After reset the ring is cleared one entry per cycle, all RING_DEPTH entries;
// full stays high during that pass. The counter and totals reset to zero.
// When the receiver holds off pop, the finished result waits in the output
// register, the executer stalls at its next result and the queue fills up.
// depends on trmh_pkg, trmh_front, trmh_back and the defines header
`default_nettype none
`include "traffic_rate_meter_with_history_defines.svh"

module traffic_rate_meter_with_history #(
  parameter int unsigned RING_DEPTH      = 64,
  parameter int unsigned REFRESH_DIVISOR = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire trmh_pkg::in_item_t in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output trmh_pkg::result_t       res_o,
  input  wire logic               cfg_we_i,
  input  wire logic [6:0]         cfg_wdata_i
);

  logic [6:0]           ring_length_q;
  trmh_pkg::front_req_t req;
  logic                 req_pop;
  logic                 init_busy;
  logic                 res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_length_q <= 7'd64;
    end else if (cfg_we_i) begin
      ring_length_q <= cfg_wdata_i;
    end
  end

  trmh_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (in_item_i),
    .block_i   (init_busy),
    .full_o    (full),
    .req_o     (req),
    .req_pop_i (req_pop)
  );

  trmh_back #(
    .RING_DEPTH      (RING_DEPTH),
    .REFRESH_DIVISOR (REFRESH_DIVISOR)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .req_pop_o     (req_pop),
    .ring_length_i (ring_length_q),
    .init_busy_o   (init_busy),
    .res_o         (res_o),
    .res_valid_o   (res_valid),
    .res_pop_i     (pop)
  );

  assign empty = !res_valid;

  // ring_length only moves on a configuration write
  `TRMH_ASSERT(a_cfg_stable, !cfg_we_i |=> $stable(ring_length_q), "ring_length changed without write")
  // no beat enters while the ring is being cleared
  `TRMH_ASSERT_ALWAYS(a_full_in_init, init_busy |-> full, "input open during ring clear")
  // nothing can have been produced before the clearing pass ends
  `TRMH_ASSERT_ALWAYS(a_empty_in_init, init_busy |-> empty, "result present during ring clear")

endmodule

`default_nettype wire

FILE: hdl/trmh_ring.sv
// speed history ring memory with clearing pass after reset
// depends on trmh_pkg
`default_nettype none

module trmh_ring #(
  parameter int unsigned RING_DEPTH = 64,
  localparam int unsigned AW = $clog2(RING_DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [trmh_pkg::PACK_W-1:0] wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output logic      [trmh_pkg::PACK_W-1:0] rd_data_o,
  output logic                             init_busy_o
);

  logic [trmh_pkg::PACK_W-1:0] ring_mem_q [RING_DEPTH];
  logic [trmh_pkg::PACK_W-1:0] rd_data_q;
  logic                        clr_busy_q;
  logic [AW-1:0]               clr_addr_q;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [trmh_pkg::PACK_W-1:0] mem_wdata;

  // clearing pass owns the write port until every entry is zero
  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en_i;
      mem_waddr = wr_addr_i;
      mem_wdata = wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= ring_mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(RING_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign rd_data_o   = rd_data_q;
  assign init_busy_o = clr_busy_q;

endmodule

`default_nettype wire

FILE: hdl/trmh_div.sv
// radix-256 restoring divider, 64-bit dividend by a divisor of up to 63
// depends on trmh_pkg
`default_nettype none

module trmh_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire trmh_pkg::div_req_t         req_i,
  output logic                            done_o,
  output logic      [trmh_pkg::CNT_W-1:0] quotient_o
);

  localparam int unsigned NCYC  = trmh_pkg::CNT_W / trmh_pkg::DIV_STEP;
  localparam int unsigned CYC_W = $clog2(NCYC);

  logic                       busy_q;
  logic                       done_q;
  logic [CYC_W-1:0]           cyc_q;
  logic [trmh_pkg::CNT_W-1:0] quo_q, quo_d;
  logic [trmh_pkg::DVS_W-1:0] rem_q, rem_d;
  logic [trmh_pkg::DVS_W-1:0] dvs_q;

  // one quotient bit per step, remainder stays below the divisor
  always_comb begin
    logic [trmh_pkg::DVS_W:0] rem_ext;
    logic                     ge;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < int'(trmh_pkg::DIV_STEP); i++) begin
      rem_ext = {rem_d, quo_d[trmh_pkg::CNT_W-1]};
      ge      = rem_ext >= {1'b0, dvs_q};
      quo_d   = {quo_d[trmh_pkg::CNT_W-2:0], ge};
      rem_d   = ge ? trmh_pkg::DVS_W'(rem_ext - {1'b0, dvs_q})
                   : rem_ext[trmh_pkg::DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cyc_q  <= '0;
    end else begin
      done_q <= busy_q && (cyc_q == CYC_W'(NCYC - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cyc_q  <= '0;
      end else if (busy_q) begin
        if (cyc_q == CYC_W'(NCYC - 1)) begin
          busy_q <= 1'b0;
        end
        cyc_q <= cyc_q + CYC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: hdl/trmh_front.sv
// front end: accepts input beats, classifies them, two-entry work queue
// depends on trmh_pkg
`default_nettype none

module trmh_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire trmh_pkg::in_item_t   item_i,
  input  wire logic                 block_i,
  output logic                      full_o,
  output trmh_pkg::front_req_t      req_o,
  input  wire logic                 req_pop_i
);

  trmh_pkg::work_t fifo_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            accept;
  trmh_pkg::work_t work_in;

  assign full_o = (cnt_q == 2'd2) || block_i;
  assign accept = push_i && !full_o;

  always_comb begin
    work_in.op     = item_i.command ? trmh_pkg::OP_TICK : trmh_pkg::OP_ADD;
    work_in.amount = item_i.byte_amount;
    work_in.slot   = item_i.slot;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fifo_q[wr_ptr_q] <= work_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (req_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (accept && !req_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!accept && req_pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_comb begin
    req_o.valid = cnt_q != 2'd0;
    req_o.work  = fifo_q[rd_ptr_q];
  end

endmodule

`default_nettype wire

FILE: hdl/trmh_back.sv
// back end: counter, totals, speed, ring history and average, result register
// depends on trmh_pkg, trmh_ring, trmh_div
`default_nettype none

module trmh_back #(
  parameter int unsigned RING_DEPTH      = 64,
  parameter int unsigned REFRESH_DIVISOR = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire trmh_pkg::front_req_t req_i,
  output logic                      req_pop_o,
  input  wire logic [6:0]           ring_length_i,
  output logic                      init_busy_o,
  output trmh_pkg::result_t         res_o,
  output logic                      res_valid_o,
  input  wire logic                 res_pop_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned IW = (AW + 1 > 8) ? AW + 1 : 8;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SPD   = 6'b000010,
    ST_RADDR = 6'b000100,
    ST_RDATA = 6'b001000,
    ST_AVG   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  function automatic logic [15:0] pack_rate(input logic [31:0] s);
    logic [15:0] r;
    if (s < trmh_pkg::PACK_LIMIT) begin
      r = s[17:2];
    end else begin
      r = {1'b1, s[24:10]};
    end
    return r;
  endfunction

  function automatic logic [31:0] unpack_rate(input logic [15:0] p);
    logic [31:0] r;
    if (!p[15]) begin
      r = {14'b0, p, 2'b0};
    end else begin
      r = {7'b0, p[14:0], 10'b0};
    end
    return r;
  endfunction

  state_e                             state_q, state_d;
  logic [trmh_pkg::CNT_W-1:0]         counter_q, counter_d;
  logic [trmh_pkg::CNT_W-1:0]         last_tick_q, last_tick_d;
  logic [trmh_pkg::TOT_W-1:0]         total_q, total_d;
  logic [trmh_pkg::SPD_W-1:0]         speed_q, speed_d;
  logic [trmh_pkg::SPD_W-1:0]         avg_q, avg_d;
  logic [trmh_pkg::SUM_W-1:0]         sum_q, sum_d;
  logic [trmh_pkg::TERM_W-1:0]        term_q, term_d;
  logic                               rd_zero_q, rd_zero_d;
  trmh_pkg::result_t                  res_q, res_d;
  logic                               res_valid_q, res_valid_d;

  logic [trmh_pkg::CNT_W-1:0]         diff;
  logic [trmh_pkg::CNT_W-1:0]         mag;
  logic [trmh_pkg::SPD_W-1:0]         sat_speed;
  logic [7:0]                         pos8, term8, rl8, hist8;
  logic [IW-1:0]                      slot_ext, hist_ext;
  logic                               slot_in_ring, hist_in_ring;

  trmh_pkg::div_req_t                 div_req;
  logic                               div_done;
  logic [trmh_pkg::CNT_W-1:0]         div_quo;

  logic                               wr_en, rd_en;
  logic [AW-1:0]                      wr_addr, rd_addr;
  logic [trmh_pkg::PACK_W-1:0]        wr_data, rd_data;

  trmh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  trmh_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data),
    .init_busy_o (init_busy_o)
  );

  // magnitude of the two's complement change since the last tick
  assign diff      = counter_q - last_tick_q;
  assign mag       = diff[trmh_pkg::CNT_W-1] ? (~diff + trmh_pkg::CNT_W'(1)) : diff;
  assign sat_speed = (|div_quo[trmh_pkg::CNT_W-1:trmh_pkg::SPD_W]) ? '1
                                                                   : div_quo[31:0];

  // history index behind the slot, wrapping at ring_length
  assign pos8  = {2'b0, req_i.work.slot};
  assign term8 = {5'b0, term_q};
  assign rl8   = {1'b0, ring_length_i};
  assign hist8 = (pos8 >= term8) ? (pos8 - term8) : (rl8 + pos8 - term8);

  assign slot_ext     = {{(IW - 6){1'b0}}, req_i.work.slot};
  assign hist_ext     = IW'(hist8);
  assign slot_in_ring = slot_ext < IW'(RING_DEPTH);
  assign hist_in_ring = hist_ext < IW'(RING_DEPTH);

  always_comb begin
    state_d          = state_q;
    counter_d        = counter_q;
    last_tick_d      = last_tick_q;
    total_d          = total_q;
    speed_d          = speed_q;
    avg_d            = avg_q;
    sum_d            = sum_q;
    term_d           = term_q;
    rd_zero_d        = rd_zero_q;
    res_d            = res_q;
    res_valid_d      = res_valid_q && !res_pop_i;
    req_pop_o        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mag;
    div_req.divisor  = trmh_pkg::DVS_W'(REFRESH_DIVISOR);
    wr_en            = 1'b0;
    wr_addr          = slot_ext[AW-1:0];
    wr_data          = pack_rate(sat_speed);
    rd_en            = 1'b0;
    rd_addr          = hist_ext[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (req_i.work.op)
            trmh_pkg::OP_ADD: begin
              counter_d = counter_q + {32'b0, req_i.work.amount};
              state_d   = ST_DONE;
            end
            trmh_pkg::OP_TICK: begin
              last_tick_d   = counter_q;
              total_d       = total_q + mag[trmh_pkg::TOT_W-1:0];
              div_req.start = 1'b1;
              state_d       = ST_SPD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SPD: begin
        if (div_done) begin
          speed_d = sat_speed;
          wr_en   = slot_in_ring;
          sum_d   = {3'b0, sat_speed};
          term_d  = trmh_pkg::TERM_W'(1);
          state_d = ST_RADDR;
        end
      end
      ST_RADDR: begin
        if ((term_q == trmh_pkg::TERM_MAX) || (ring_length_i < {4'b0, term_q})) begin
          div_req.start    = 1'b1;
          div_req.dividend = {29'b0, sum_q};
          div_req.divisor  = {3'b0, term_q};
          state_d          = ST_AVG;
        end else begin
          rd_en     = hist_in_ring;
          rd_zero_d = !hist_in_ring;
          state_d   = ST_RDATA;
        end
      end
      ST_RDATA: begin
        sum_d   = sum_q + {3'b0, unpack_rate(rd_zero_q ? '0 : rd_data)};
        term_d  = term_q + trmh_pkg::TERM_W'(1);
        state_d = ST_RADDR;
      end
      ST_AVG: begin
        if (div_done) begin
          avg_d   = div_quo[31:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid_q || res_pop_i) begin
          res_d.current_speed  = speed_q;
          res_d.speed_code     = pack_rate(speed_q);
          res_d.average_speed  = avg_q;
          res_d.byte_count     = counter_q[trmh_pkg::TOT_W-1:0];
          // the three report totals always move together
          res_d.report_total_a = total_q;
          res_d.report_total_b = total_q;
          res_d.db_total       = total_q;
          res_valid_d          = 1'b1;
          req_pop_o            = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      counter_q   <= '0;
      last_tick_q <= '0;
      total_q     <= '0;
      speed_q     <= '0;
      avg_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      counter_q   <= counter_d;
      last_tick_q <= last_tick_d;
      total_q     <= total_d;
      speed_q     <= speed_d;
      avg_q       <= avg_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    term_q    <= term_d;
    rd_zero_q <= rd_zero_d;
    res_q     <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

FILE: sim/tb_traffic_rate_meter_with_history.sv
// testbench for traffic_rate_meter_with_history: directed and random byte adds and
// refresh ticks over several ring lengths, each result checked against a local predictor
// depends on trmh_pkg and the traffic_rate_meter_with_history top level
`timescale 1ns / 100ps

module tb_traffic_rate_meter_with_history;

  localparam int unsigned RING_DEPTH  = 64;
  localparam int unsigned REFRESH_DIV = 1;
  localparam int unsigned BEATS_PER_SETTING = 215;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               push      = 1'b0;
  logic               full;
  trmh_pkg::in_item_t in_item   = '0;
  logic               empty;
  logic               pop       = 1'b0;
  trmh_pkg::result_t  res;
  logic               cfg_we    = 1'b0;
  logic [6:0]         cfg_wdata = 7'd0;

  // predictor state
  logic [63:0] byte_counter    = '0;
  logic [63:0] counter_at_tick = '0;
  logic [63:0] sum_a           = '0;
  logic [63:0] sum_b           = '0;
  logic [63:0] sum_db          = '0;
  logic [15:0] speed_hist [RING_DEPTH];
  logic [31:0] speed_now       = '0;
  logic [31:0] speed_avg       = '0;
  logic [6:0]  ring_len        = 7'd64;

  trmh_pkg::in_item_t pending_beats [$];
  trmh_pkg::result_t  expected_reports [$];

  int unsigned gap_left    = 0;
  int unsigned burst_left  = 0;
  logic [15:0] pop_pattern = 16'hFFFF;
  logic [7:0]  pop_phase   = '0;

  int unsigned errors    = 0;
  int unsigned n_beats   = 0;
  int unsigned n_ticks   = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 1;

  traffic_rate_meter_with_history #(
    .RING_DEPTH      (RING_DEPTH),
    .REFRESH_DIVISOR (REFRESH_DIV)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [15:0] squeeze_speed(input logic [31:0] s);
    if (s < 32'd131072) return s[17:2];
    return {1'b1, s[24:10]};
  endfunction

  function automatic logic [31:0] expand_speed(input logic [15:0] p);
    if (!p[15]) return {14'd0, p, 2'b00};
    return {7'd0, p[14:0], 10'd0};
  endfunction

  // applies one beat to the predictor state and returns the result it should give
  function automatic trmh_pkg::result_t advance_meter(input trmh_pkg::in_item_t beat);
    logic [63:0] change;
    logic [63:0] mag;
    logic [63:0] q;
    logic [34:0] sum;
    int unsigned terms;
    int unsigned idx;
    logic [15:0] entry;
    trmh_pkg::result_t r;
    if (beat.command == trmh_pkg::OP_TICK) begin
      change = byte_counter - counter_at_tick;
      counter_at_tick = byte_counter;
      mag = change[63] ? (~change + 64'd1) : change;
      q = mag / REFRESH_DIV;
      speed_now = (q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      if (beat.slot < RING_DEPTH) speed_hist[beat.slot] = squeeze_speed(speed_now);
      if (mag != 0) begin
        sum_a  = sum_a + mag;
        sum_b  = sum_b + mag;
        sum_db = sum_db + mag;
      end
      sum = {3'd0, speed_now};
      terms = 1;
      // walk back through the ring, wrapping at the configured length
      for (int c = 1; c < 5; c++) begin
        if (ring_len < c) break;
        idx = (beat.slot >= c) ? beat.slot - c : ring_len + beat.slot - c;
        entry = (idx < RING_DEPTH) ? speed_hist[idx] : 16'd0;
        sum = sum + {3'd0, expand_speed(entry)};
        terms++;
      end
      speed_avg = 32'(sum / terms);
    end else begin
      byte_counter = byte_counter + {32'd0, beat.byte_amount};
    end
    r.current_speed  = speed_now;
    r.speed_code     = squeeze_speed(speed_now);
    r.average_speed  = speed_avg;
    r.byte_count     = byte_counter[62:0];
    r.report_total_a = sum_a[62:0];
    r.report_total_b = sum_b[62:0];
    r.db_total       = sum_db[62:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // sender: bursts of random length, random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin : sender
    logic nxt_push;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      nxt_push = push;
      if (push && !full) begin
        expected_reports.push_back(advance_meter(in_item));
        n_beats++;
        if (in_item.command == trmh_pkg::OP_TICK) n_ticks++;
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_beats.size() != 0) begin
          in_item <= pending_beats.pop_front();
          nxt_push = 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      push <= nxt_push;
    end
  end

  // receiver: pop follows a rotating pattern, swapped each time the 8-bit pop_phase wraps
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    logic [15:0]       nxt_pattern;
    trmh_pkg::result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual %0h", $time, res);
        end else begin
          want = expected_reports.pop_front();
          check_field("current_speed", 64'(want.current_speed), 64'(res.current_speed));
          check_field("speed_code", 64'(want.speed_code), 64'(res.speed_code));
          check_field("average_speed", 64'(want.average_speed), 64'(res.average_speed));
          check_field("byte_count", 64'(want.byte_count), 64'(res.byte_count));
          check_field("report_total_a", 64'(want.report_total_a),
                      64'(res.report_total_a));
          check_field("report_total_b", 64'(want.report_total_b),
                      64'(res.report_total_b));
          check_field("db_total", 64'(want.db_total), 64'(res.db_total));
          n_checked++;
        end
      end
      nxt_pattern = {pop_pattern[0], pop_pattern[15:1]};
      pop_phase++;
      if (pop_phase == 8'd0) begin
        // bit 0 always set so a stall never lasts a whole pattern
        case ($urandom_range(0, 2))
          0: nxt_pattern = 16'hFFFF;
          1: nxt_pattern = 16'($urandom) | 16'h0001;
          default: nxt_pattern = 16'($urandom & $urandom) | 16'h0001;
        endcase
      end
      pop <= pop_pattern[0];
      pop_pattern <= nxt_pattern;
    end
  end

  task automatic queue_beat(input trmh_pkg::op_e op, input logic [31:0] amount,
                            input logic [5:0] slot);
    trmh_pkg::in_item_t beat;
    beat.command     = op;
    beat.byte_amount = amount;
    beat.slot        = slot;
    pending_beats.push_back(beat);
  endtask

  // waits until every beat is in and every result is out, checking the idle
  // state at consecutive edges so a beat loaded at the same edge is caught
  task automatic wait_idle();
    int unsigned quiet;
    quiet = 0;
    while (quiet < 2) begin
      @(posedge clk_i);
      if (pending_beats.size() != 0 || push || expected_reports.size() != 0)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  task automatic set_ring_length(input logic [6:0] len);
    cfg_wdata <= len;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    ring_len = len;
    n_settings++;
  endtask

  // mostly runs of adds closed by a tick, with some lone beats as noise
  task automatic queue_random_traffic(input int unsigned n);
    int unsigned made;
    int unsigned adds;
    logic [31:0] amount;
    logic [5:0]  slot;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_beat(trmh_pkg::op_e'($urandom_range(0, 1)), $urandom, 6'($urandom));
        made++;
      end else begin
        adds = $urandom_range(0, 6);
        repeat (adds) begin
          case ($urandom_range(0, 19))
            0:       amount = 32'd0;
            1, 2:    amount = 32'hFFFF_FFFF;
            3, 4, 5, 6, 7, 8, 9, 10: amount = $urandom_range(0, 255);
            11, 12, 13, 14, 15: amount = $urandom_range(0, 200000);
            default: amount = $urandom;
          endcase
          queue_beat(trmh_pkg::OP_ADD, amount, 6'($urandom));
          made++;
        end
        slot = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, ring_len - 1))
                                          : 6'($urandom);
        queue_beat(trmh_pkg::OP_TICK, $urandom, slot);
        made++;
      end
    end
  endtask

  initial begin
    logic [6:0] lengths [8];
    for (int i = 0; i < RING_DEPTH; i++) speed_hist[i] = 16'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero change, saturation, exact max, packing boundary, ring wrap
    queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd0);
    queue_beat(trmh_pkg::OP_ADD, 32'd0, 6'd0);
    queue_beat(trmh_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd63);
    queue_beat(trmh_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd0);
    queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd63);
    queue_beat(trmh_pkg::OP_ADD, 32'd131071, 6'd0);
    queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd1);
    queue_beat(trmh_pkg::OP_ADD, 32'd131072, 6'd0);
    queue_beat(trmh_pkg::OP_TICK, 32'hFFFF_FFFF, 6'd2);
    queue_beat(trmh_pkg::OP_ADD, 32'd3, 6'd0);
    queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd3);
    queue_beat(trmh_pkg::OP_ADD, 32'h5555_5555, 6'd21);
    queue_beat(trmh_pkg::OP_ADD, 32'hAAAA_AAAA, 6'd42);
    queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd4);
    queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd5);
    queue_beat(trmh_pkg::OP_ADD, 32'd1, 6'd0);
    queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd32);
    queue_beat(trmh_pkg::OP_ADD, 32'd4, 6'd0);
    queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd63);
    queue_random_traffic(BEATS_PER_SETTING - 19);

    lengths[0] = 7'd1;
    lengths[1] = 7'd2;
    lengths[2] = 7'd3;
    lengths[3] = 7'd4;
    lengths[4] = 7'd5;
    lengths[5] = 7'd64;
    lengths[6] = 7'($urandom_range(6, 63));
    lengths[7] = 7'($urandom_range(1, 64));
    foreach (lengths[i]) begin
      wait_idle();
      set_ring_length(lengths[i]);
      if (lengths[i] == 7'd1) begin
        // single slot ring: the average reads back the entry just written
        queue_beat(trmh_pkg::OP_ADD, 32'd1000, 6'd0);
        queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd0);
        queue_beat(trmh_pkg::OP_TICK, 32'd0, 6'd63);
      end
      queue_random_traffic(BEATS_PER_SETTING);
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_reports.size());
    end
    $display("run covered %0d beats, %0d of them refresh ticks, over %0d ring lengths",
             n_beats, n_ticks, n_settings);
    $display("%0d results compared, %0d field mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
